>>> sv/gdoc_pkg.sv
package gdoc_pkg;
    localparam int MaxNodes   = 64;
    localparam int NodeBits   = 6;
    localparam int CountBits  = 7;
    localparam int DegreeBits = 16;
    localparam int ColorBits  = 7;
    localparam logic [ColorBits-1:0] Uncolored = 7'd127;
    localparam logic [DegreeBits-1:0] DegreeMax = {DegreeBits{1'b1}};
    localparam logic [CountBits-1:0] NodeCountReset = 7'd64;
    localparam logic FuncEdge  = 1'b0;
    localparam logic FuncColor = 1'b1;
endpackage

>>> sv/gdoc_rank.sv
// Rank unit: counts how many in-use nodes go before the node under rank (i_node).
// One comparison per cycle against a walking index; probe data arrives
// in the cycle after its index goes out.
module gdoc_rank (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [gdoc_pkg::NodeBits-1:0]       i_node,
    input  logic [gdoc_pkg::DegreeBits-1:0]     i_node_deg,
    input  logic [gdoc_pkg::CountBits-1:0]      i_n,
    output logic [gdoc_pkg::NodeBits-1:0]       o_probe,
    input  logic [gdoc_pkg::DegreeBits-1:0]     i_probe_deg,
    output logic                                o_done,
    output logic [gdoc_pkg::NodeBits-1:0]       o_rank
);
    import gdoc_pkg::*;

    logic                 r_busy;
    logic                 r_cmp;
    logic                 r_last;
    logic [NodeBits-1:0]  r_cmp_idx;
    logic [CountBits-1:0] r_idx;
    logic [CountBits-1:0] r_cnt;
    logic                 w_first;

    assign o_probe = r_idx[NodeBits-1:0];
    assign w_first = (i_probe_deg > i_node_deg) ||
                     (i_probe_deg == i_node_deg && r_cmp_idx > i_node);
    assign o_rank  = r_cnt[NodeBits-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cmp     <= 1'b0;
            r_last    <= 1'b0;
            r_cmp_idx <= '0;
            o_done    <= 1'b0;
            r_idx     <= '0;
            r_cnt     <= '0;
        end else begin
            o_done <= 1'b0;
            r_cmp  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_cnt  <= '0;
            end else begin
                if (r_busy) begin
                    r_cmp     <= 1'b1;
                    r_cmp_idx <= r_idx[NodeBits-1:0];
                    r_last    <= (r_idx + 1'b1 >= i_n);
                    if (r_idx + 1'b1 >= i_n) r_busy <= 1'b0;
                    r_idx <= r_idx + 1'b1;
                end
                if (r_cmp) begin
                    if (w_first) r_cnt <= r_cnt + 1'b1;
                    if (r_last) o_done <= 1'b1;
                end
            end
        end
    end
endmodule

>>> sv/greedy_degree_order_graph_coloring_core.sv
// Edge load: degree slots are read at accept and written back in the next cycle.
// Color run: nodes are ranked into visit order, then up to 64 passes of n visits;
// a visit reads the node and, when uncolored, scans its neighbors one per cycle.
// Results then leave one at a time, held during receiver stalls, then 64 slots clear.
// One request at a time. Reset clears control and starts the clear of all 64 slots;
// node_count resets to 64.
module greedy_degree_order_graph_coloring_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gdoc_pkg::CountBits-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_func,
    input  logic [gdoc_pkg::NodeBits-1:0]     i_edge_from,
    input  logic [gdoc_pkg::NodeBits-1:0]     i_edge_to,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [gdoc_pkg::NodeBits-1:0]     o_node_id,
    output logic [gdoc_pkg::NodeBits-1:0]     o_node_color,
    output logic                              o_last
);
    import gdoc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EDGE, S_RANK_GO, S_RANK_WAIT, S_VISIT, S_VISIT_RD,
        S_VISIT_CHK, S_SCAN, S_EMIT_RD, S_EMIT
    } t_state;

    t_state                r_state;
    logic [CountBits-1:0]  r_cfg;
    logic [CountBits-1:0]  r_n;
    logic [CountBits-1:0]  r_i;
    logic [CountBits-1:0]  r_j;
    logic [CountBits-1:0]  r_colored;
    logic [CountBits-1:0]  r_color;
    logic [NodeBits-1:0]   r_a;
    logic [NodeBits-1:0]   r_b;
    logic [NodeBits-1:0]   r_v;
    logic [MaxNodes-1:0]   r_row;
    logic [DegreeBits-1:0] r_deg_a;
    logic [DegreeBits-1:0] r_deg_b;
    logic [DegreeBits-1:0] r_node_deg;
    logic [DegreeBits-1:0] r_probe_deg;
    logic [ColorBits-1:0]  r_vcol;
    logic [ColorBits-1:0]  r_jcol;
    logic                  r_jbit;
    logic                  r_jv;

    logic [MaxNodes-1:0]   r_adj   [MaxNodes];
    logic [DegreeBits-1:0] r_deg   [MaxNodes];
    logic [ColorBits-1:0]  r_col   [MaxNodes];
    logic [NodeBits-1:0]   r_order [MaxNodes];

    logic                  w_rank_done;
    logic [NodeBits-1:0]   w_rank;
    logic [NodeBits-1:0]   w_probe;
    logic [CountBits-1:0]  w_n;
    logic [DegreeBits:0]   w_sum_a;
    logic [DegreeBits:0]   w_sum_b;

    assign w_n = (r_cfg > CountBits'(MaxNodes)) ? CountBits'(MaxNodes) : r_cfg;
    assign o_stall = (r_state != S_IDLE);

    gdoc_rank u_rank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_RANK_GO),
        .i_node     (r_i[NodeBits-1:0]),
        .i_node_deg (r_node_deg),
        .i_n        (r_n),
        .o_probe    (w_probe),
        .i_probe_deg(r_probe_deg),
        .o_done     (w_rank_done),
        .o_rank     (w_rank)
    );

    // ranks are distinct, so ordering by rank equals the sorted visit order
    assign w_sum_a = {1'b0, r_deg_a} + ((r_a == r_b) ? 17'd2 : 17'd1);
    assign w_sum_b = {1'b0, r_deg_b} + 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cfg   <= NodeCountReset;
            r_i     <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_data;
            case (r_state)
                S_CLEAR: begin
                    r_adj[r_i[NodeBits-1:0]] <= '0;
                    r_deg[r_i[NodeBits-1:0]] <= '0;
                    r_col[r_i[NodeBits-1:0]] <= Uncolored;
                    r_i <= r_i + 1'b1;
                    if (r_i == CountBits'(MaxNodes - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_a     <= i_edge_from;
                        r_b     <= i_edge_to;
                        r_deg_a <= r_deg[i_edge_from];
                        r_deg_b <= r_deg[i_edge_to];
                        r_n     <= w_n;
                        r_i     <= '0;
                        if (i_func == FuncEdge) r_state <= S_EDGE;
                        else if (w_n == '0) r_state <= S_CLEAR;
                        else r_state <= S_RANK_GO;
                    end
                end
                S_EDGE: begin
                    if (r_a == r_b) begin
                        r_deg[r_a] <= w_sum_a[DegreeBits] ? DegreeMax
                                                          : w_sum_a[DegreeBits-1:0];
                    end else begin
                        r_deg[r_a] <= w_sum_a[DegreeBits] ? DegreeMax
                                                          : w_sum_a[DegreeBits-1:0];
                        r_deg[r_b] <= w_sum_b[DegreeBits] ? DegreeMax
                                                          : w_sum_b[DegreeBits-1:0];
                        r_adj[r_a][r_b] <= 1'b1;
                        r_adj[r_b][r_a] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_RANK_GO: begin
                    r_node_deg <= r_deg[r_i[NodeBits-1:0]];
                    r_state    <= S_RANK_WAIT;
                end
                S_RANK_WAIT: begin
                    r_probe_deg <= r_deg[w_probe];
                    if (w_rank_done) begin
                        r_order[w_rank] <= r_i[NodeBits-1:0];
                        if (r_i + 1'b1 >= r_n) begin
                            r_i       <= '0;
                            r_colored <= '0;
                            r_color   <= '0;
                            r_state   <= S_VISIT;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_RANK_GO;
                        end
                    end
                end
                S_VISIT: begin
                    if (r_colored >= r_n || r_color >= CountBits'(MaxNodes)) begin
                        r_i     <= '0;
                        r_state <= S_EMIT_RD;
                    end else if (r_i >= r_n) begin
                        r_i     <= '0;
                        r_color <= r_color + 1'b1;
                    end else begin
                        r_v     <= r_order[r_i[NodeBits-1:0]];
                        r_state <= S_VISIT_RD;
                    end
                end
                S_VISIT_RD: begin
                    r_vcol  <= r_col[r_v];
                    r_row   <= r_adj[r_v];
                    r_state <= S_VISIT_CHK;
                end
                S_VISIT_CHK: begin
                    if (r_vcol != Uncolored) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_VISIT;
                    end else begin
                        r_j     <= '0;
                        r_jv    <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // one neighbor per cycle; color and row bits are registered, so the check trails the index
                    r_jcol <= r_col[r_j[NodeBits-1:0]];
                    r_jbit <= r_row[r_j[NodeBits-1:0]];
                    r_jv   <= (r_j < r_n);
                    r_j    <= r_j + 1'b1;
                    if (r_jv && r_jbit && r_jcol == r_color) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_VISIT;
                    end else if (r_j > r_n) begin
                        r_col[r_v] <= r_color;
                        r_colored  <= r_colored + 1'b1;
                        r_i        <= r_i + 1'b1;
                        r_state    <= S_VISIT;
                    end
                end
                S_EMIT_RD: begin
                    o_node_id    <= r_i[NodeBits-1:0];
                    o_node_color <= r_col[r_i[NodeBits-1:0]][NodeBits-1:0];
                    o_last       <= (r_i + 1'b1 == r_n);
                    o_valid      <= 1'b1;
                    r_state      <= S_EMIT;
                end
                S_EMIT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        if (r_i + 1'b1 >= r_n) begin
                            r_i     <= '0;
                            r_state <= S_CLEAR;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end
endmodule
